// ===== rtl/deq_pkg.sv =====
package deq_pkg;

  localparam int OP_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam int STATUS_BITS = 2;
  localparam int OCC_BITS = 5;

  localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_BITS-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [OP_BITS-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OP_BITS-1:0] OP_PEEK_REAR  = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [DATA_BITS-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]   read_value;
    logic [STATUS_BITS-1:0] status;
    logic [OCC_BITS-1:0]    occupancy;
  } rsp_t;

  // what the control hands to the result stage for one beat
  typedef struct packed {
    logic                   is_read;
    logic [STATUS_BITS-1:0] status;
    logic [OCC_BITS-1:0]    occupancy;
  } info_t;

endpackage

// ===== rtl/deq_ram.sv =====
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/deq_ctrl.sv =====
module deq_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [deq_pkg::OP_BITS-1:0]   op,
  output logic                          mem_we,
  output logic                          mem_re,
  output logic [$clog2(DEPTH)-1:0]      mem_addr,
  output deq_pkg::info_t                info
);
  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [IW-1:0] front, front_next;
  logic [IW-1:0] rear, rear_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] front_inc, front_dec, rear_inc, rear_dec;
  logic          full, empty;

  assign front_inc = (front == LAST_SLOT) ? '0 : front + IW'(1);
  assign front_dec = (front == '0) ? LAST_SLOT : front - IW'(1);
  assign rear_inc  = (rear == LAST_SLOT) ? '0 : rear + IW'(1);
  assign rear_dec  = (rear == '0) ? LAST_SLOT : rear - IW'(1);
  assign full  = (count == FULL_COUNT);
  assign empty = (count == '0);

  always_comb begin
    front_next   = front;
    rear_next    = rear;
    count_next   = count;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = front;
    info.is_read = 1'b0;
    info.status  = ST_OK;
    case (op)
      OP_PUSH_FRONT: begin
        if (full) begin
          info.status = ST_FULL;
        end else begin
          mem_we     = accept;
          mem_addr   = front_dec;
          front_next = front_dec;
          count_next = count + CW'(1);
        end
      end
      OP_PUSH_REAR: begin
        if (full) begin
          info.status = ST_FULL;
        end else begin
          mem_we     = accept;
          mem_addr   = rear;
          rear_next  = rear_inc;
          count_next = count + CW'(1);
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (empty) begin
          info.status = ST_EMPTY;
        end else begin
          mem_re       = accept;
          mem_addr     = front;
          info.is_read = 1'b1;
          if (op == OP_POP_FRONT) begin
            front_next = front_inc;
            count_next = count - CW'(1);
          end
        end
      end
      OP_POP_REAR, OP_PEEK_REAR: begin
        if (empty) begin
          info.status = ST_EMPTY;
        end else begin
          mem_re       = accept;
          mem_addr     = rear_dec;
          info.is_read = 1'b1;
          if (op == OP_POP_REAR) begin
            rear_next  = rear_dec;
            count_next = count - CW'(1);
          end
        end
      end
      default: begin
        // unused codes leave everything alone
      end
    endcase
    info.occupancy = OCC_BITS'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      rear  <= rear_next;
      count <= count_next;
    end
  end

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// Deque of DEPTH words in a ring held in one synchronous RAM.
// An accepted beat moves through s1, where the RAM read completes, into the rsp output register.
// Throughput: one operation per cycle unless rsp_ready stalls; the single RAM port serves the one
// read or write each operation needs, and pointers and count update at accept.
// Reset (rst, synchronous): empty queue, pointers at slot zero, no result held.
// The RAM has no reset; entries are read only after they were written.
module double_ended_queue_unit #(
  parameter int DEPTH = 16,
  parameter int WORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  deq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output deq_pkg::rsp_t rsp
);
  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic                 accept;
  logic                 mem_we, mem_re;
  logic [IW-1:0]        mem_addr;
  logic [WORD_BITS-1:0] mem_rdata;
  info_t                ctrl_info;
  logic                 s1_valid;
  info_t                s1_info;
  logic                 s1_move;

  // s1 holds the beat while the RAM read completes; rsp is the output register
  assign s1_move   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_move;
  assign accept    = req_valid && req_ready;

  deq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .op       (req.op),
    .mem_we   (mem_we),
    .mem_re   (mem_re),
    .mem_addr (mem_addr),
    .info     (ctrl_info)
  );

  // read data only changes on a read, so it holds while s1 is stalled
  deq_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (WORD_BITS'(req.push_value)),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= ctrl_info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.read_value <= s1_info.is_read ? DATA_BITS'(mem_rdata) : '0;
      rsp.status     <= s1_info.status;
      rsp.occupancy  <= s1_info.occupancy;
    end
  end

  a_ram_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    (mem_we || mem_re) |-> accept)
    else $error("ram access without an accepted beat");

  a_full_reports_depth: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_info.status == ST_FULL) |-> (s1_info.occupancy == OCC_BITS'(DEPTH)))
    else $error("refused push with occupancy other than depth");

  a_empty_reports_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_info.status == ST_EMPTY) |-> (s1_info.occupancy == '0 && !s1_info.is_read))
    else $error("empty status with non-zero occupancy or a read");

  a_s1_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> (s1_valid && $stable(s1_info)))
    else $error("stalled beat lost from s1");

endmodule

// ===== tb/deq_checker.sv =====
module deq_checker
  import deq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   mismatches,
  output int   pending,
  output int   results_checked,
  output int   full_refusals,
  output int   empty_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int REPORT_LIMIT = 10;

  logic [WORD_BITS-1:0] ring_words [DEPTH];
  logic [PTR_BITS-1:0]  head_slot;
  logic [PTR_BITS-1:0]  tail_slot;
  logic [OCC_BITS-1:0]  held_words;
  rsp_t                 awaited_rsp [$];

  function automatic logic [PTR_BITS-1:0] step_up(logic [PTR_BITS-1:0] slot);
    return (int'(slot) == DEPTH - 1) ? '0 : slot + 1'b1;
  endfunction

  function automatic logic [PTR_BITS-1:0] step_down(logic [PTR_BITS-1:0] slot);
    return (slot == '0) ? PTR_BITS'(DEPTH - 1) : slot - 1'b1;
  endfunction

  // applies one operation to the shadow deque and returns the result it owes
  function automatic rsp_t apply_operation(req_t r);
    rsp_t                res;
    logic [PTR_BITS-1:0] slot;
    res = '0;
    case (r.op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (int'(held_words) >= DEPTH) begin
          res.status = ST_FULL;
        end else if (r.op == OP_PUSH_FRONT) begin
          head_slot = step_down(head_slot);
          ring_words[head_slot] = r.push_value[WORD_BITS-1:0];
          held_words = held_words + 1'b1;
        end else begin
          ring_words[tail_slot] = r.push_value[WORD_BITS-1:0];
          tail_slot = step_up(tail_slot);
          held_words = held_words + 1'b1;
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (held_words == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.read_value = DATA_BITS'(ring_words[head_slot]);
          if (r.op == OP_POP_FRONT) begin
            head_slot = step_up(head_slot);
            held_words = held_words - 1'b1;
          end
        end
      end
      OP_POP_REAR, OP_PEEK_REAR: begin
        if (held_words == '0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = step_down(tail_slot);
          res.read_value = DATA_BITS'(ring_words[slot]);
          if (r.op == OP_POP_REAR) begin
            tail_slot = slot;
            held_words = held_words - 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.occupancy = held_words;
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      head_slot = '0;
      tail_slot = '0;
      held_words = '0;
      awaited_rsp.delete();
    end else begin
      if (req_valid && req_ready) begin
        want = apply_operation(req);
        if (want.status == ST_FULL) full_refusals++;
        if (want.status == ST_EMPTY) empty_hits++;
        awaited_rsp.push_back(want);
      end
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("[%0t] result beat with nothing outstanding:", $realtime);
          if (mismatches <= REPORT_LIMIT)
            $display("  value %h status %0d occ %0d",
                     rsp.read_value, rsp.status, rsp.occupancy);
        end else begin
          want = awaited_rsp.pop_front();
          results_checked++;
          if (rsp.read_value !== want.read_value || rsp.status !== want.status ||
              rsp.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("[%0t] result %0d wrong: expected value %h status %0d occ %0d,",
                       $realtime, results_checked, want.read_value, want.status,
                       want.occupancy);
              $display("  got value %h status %0d occ %0d",
                       rsp.read_value, rsp.status, rsp.occupancy);
            end
          end
        end
      end
    end
    pending = awaited_rsp.size();
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import deq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1725;
  localparam int HOLD_AFTER_ITEMS = 700;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  // op codes the block has no operation for
  localparam logic [OP_BITS-1:0] OP_SPARE_LOW  = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_HIGH = 3'd7;

  typedef enum {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_e;
  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_pattern_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int mismatches;
  int pending;
  int results_checked;
  int full_refusals;
  int empty_hits;

  int items_sent = 0;
  int burst_left = 0;
  bit draining = 1'b0;
  bit long_hold_done = 1'b0;

  double_ended_queue_unit #(
    .DEPTH(QUEUE_DEPTH),
    .WORD_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  deq_checker #(
    .DEPTH(QUEUE_DEPTH),
    .WORD_BITS(32)
  ) deq_check (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .mismatches(mismatches),
    .pending(pending),
    .results_checked(results_checked),
    .full_refusals(full_refusals),
    .empty_hits(empty_hits)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // offers one operation, idling between bursts, and waits for its beat
  task automatic offer(input logic [OP_BITS-1:0] op, input logic [DATA_BITS-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= req_t'{op: op, push_value: value};
    do @(posedge clk); while (!req_ready);
    items_sent++;
  endtask

  function automatic logic [OP_BITS-1:0] pick_op(lean_e lean);
    int roll;
    int push_share;
    roll = $urandom_range(99);
    push_share = (lean == LEAN_FILL) ? 70 : (lean == LEAN_DRAIN) ? 25 : 45;
    if (roll < 3)
      return $urandom_range(1) ? OP_SPARE_HIGH : OP_SPARE_LOW;
    if (roll < 3 + push_share)
      return $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
    if ($urandom_range(3) != 0)
      return $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
    return $urandom_range(1) ? OP_PEEK_REAR : OP_PEEK_FRONT;
  endfunction

  function automatic logic [DATA_BITS-1:0] pick_value();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return DATA_BITS'($urandom);
  endfunction

  initial begin : stimulus
    lean_e lean;
    int    lean_left;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty queue, spare codes, fill to the brim, refused pushes, then both ends
    offer(OP_PEEK_FRONT, '1);
    offer(OP_PEEK_REAR, '1);
    offer(OP_POP_FRONT, '1);
    offer(OP_POP_REAR, '1);
    offer(OP_SPARE_LOW, '1);
    offer(OP_SPARE_HIGH, '1);
    offer(OP_PUSH_FRONT, '0);
    offer(OP_PUSH_REAR, '1);
    for (int i = 2; i < QUEUE_DEPTH; i++)
      offer((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR, DATA_BITS'($urandom));
    offer(OP_PUSH_FRONT, '1);
    offer(OP_PUSH_REAR, '0);
    offer(OP_PEEK_FRONT, '0);
    offer(OP_PEEK_REAR, '0);

    lean = LEAN_EVEN;
    lean_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (lean_left == 0) begin
        lean = lean_e'($urandom_range(2));
        lean_left = $urandom_range(20, 80);
      end
      lean_left--;
      offer(pick_op(lean), pick_value());
    end
    req_valid <= 1'b0;

    draining = 1'b1;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d operations; %0d result beats checked", items_sent, results_checked);
    $display("pushes refused on a full queue: %0d, reads on an empty queue: %0d",
             full_refusals, empty_hits);
    if (mismatches == 0 && pending == 0) begin
      $display("double_ended_queue_unit test passed");
    end else begin
      $display("double_ended_queue_unit test failed");
    end
    $finish;
  end

  initial begin : receiver
    rx_pattern_e pattern;
    int          seg_left;
    int          period;
    int          tick;
    int          held;
    pattern = RX_OPEN;
    seg_left = 0;
    period = 2;
    tick = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!long_hold_done && !draining && items_sent >= HOLD_AFTER_ITEMS) begin
        // long hold-off so the deque backs up and stalls its input
        long_hold_done = 1'b1;
        rsp_ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end else if (draining) begin
        rsp_ready <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          pattern = rx_pattern_e'($urandom_range(3));
          seg_left = $urandom_range(20, 120);
          period = $urandom_range(2, 5);
          tick = 0;
        end
        seg_left--;
        tick++;
        case (pattern)
          RX_OPEN:     rsp_ready <= 1'b1;
          RX_MOSTLY:   rsp_ready <= ($urandom_range(3) != 0);
          RX_SPARSE:   rsp_ready <= ($urandom_range(3) == 0);
          RX_PERIODIC: rsp_ready <= (tick % period == 0);
          default:     rsp_ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("no beat for %0d cycles, %0d results outstanding", quiet_cycles, pending);
          $display("double_ended_queue_unit test failed");
          $finish;
        end
      end
    end
  end

endmodule

// ===== sim.f =====
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_unit.sv
tb/deq_checker.sv
tb/tb_top.sv
